### hw/rtl/arpc_pkg.sv
package arpc_pkg;

	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'h0001;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd1;

	typedef enum logic [2:0] {
		ST_BAD_HW    = 3'd0,
		ST_BAD_PROTO = 3'd1,
		ST_NOT_US    = 3'd2,
		ST_UNSUP_OP  = 3'd3,
		ST_REPLY     = 3'd4,
		ST_HIT       = 3'd5,
		ST_MISS      = 3'd6
	} status_t;

	typedef enum logic {
		MODE_PACKET = 1'b0,
		MODE_LOOKUP = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [15:0] opcode;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [31:0] lookup_ip;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [47:0] reply_mac;
		logic [31:0] reply_ip;
		logic [47:0] found_mac;
	} out_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} entry_t;

endpackage

### hw/rtl/arpc_ram.sv
module arpc_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/arp_responder_with_cache_top.sv
// flow: a malformed packet skips the cache scan and goes straight to the finish
// state; any other transaction scans the cache memory, one entry read per cycle
// through its single read port, and stops at the first hit
// throughput: one transaction at a time, busy stays high until the result strobe
// reset: asynchronous, clears all valid bits, the insert pointer and own_ip at once
// results are shown for one cycle on done; the receiver cannot stall
module arp_responder_with_cache_top
	import arpc_pkg::*;
#(
	parameter int CACHE_ENTRIES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_t                   item,
	output logic                  done,
	output out_t                  result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IDX_W = $clog2(CACHE_ENTRIES);
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} state_t;

	state_t               state_q;
	in_t                  req_q;
	logic [31:0]          own_ip_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [47:0]          hit_mac_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	entry_t               ram_wdata;
	logic                 ram_re;
	entry_t               ram_rdata;

	logic [31:0]          key;
	logic                 pkt_ok;
	logic                 for_us;
	logic                 match;
	logic                 insert;
	out_t                 fin_res;

	assign busy   = (state_q != S_IDLE);
	assign key    = (req_q.mode == MODE_LOOKUP) ? req_q.lookup_ip : req_q.sender_ip;
	assign pkt_ok = (req_q.mode == MODE_PACKET) && (req_q.hw_type == HW_ETHERNET) &&
			(req_q.proto_type == PROTO_IPV4);
	assign for_us = (req_q.target_ip == own_ip_q);
	assign match  = pend_s1 && valid_q[addr_s1] && (ram_rdata.ip == key);
	assign ram_re = (state_q == S_SEARCH) && (cnt_q < CNT_END);
	assign insert = (state_q == S_FINISH) && pkt_ok && !hit_q && for_us;

	always_comb begin
		ram_we        = (state_q == S_FINISH) && pkt_ok && (hit_q || for_us);
		ram_waddr     = hit_q ? hit_idx_q : ptr_q;
		ram_wdata.ip  = req_q.sender_ip;
		ram_wdata.mac = req_q.sender_mac;
	end

	always_comb begin
		fin_res = '0;
		if (req_q.mode == MODE_LOOKUP) begin
			fin_res.status = hit_q ? ST_HIT : ST_MISS;
			if (hit_q) begin
				fin_res.found_mac = hit_mac_q;
			end
		end else if (req_q.hw_type != HW_ETHERNET) begin
			fin_res.status = ST_BAD_HW;
		end else if (req_q.proto_type != PROTO_IPV4) begin
			fin_res.status = ST_BAD_PROTO;
		end else if (!for_us) begin
			fin_res.status = ST_NOT_US;
		end else if (req_q.opcode == OP_REQUEST) begin
			fin_res.status    = ST_REPLY;
			fin_res.reply_mac = req_q.sender_mac;
			fin_res.reply_ip  = req_q.sender_ip;
		end else begin
			fin_res.status = ST_UNSUP_OP;
		end
	end

	arpc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CACHE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
		end else if (cfg_we && (cfg_idx == CFG_OWN_IP)) begin
			own_ip_q <= cfg_wdata[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= (state_q == S_FINISH);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= item;
						cnt_q   <= '0;
						pend_s1 <= 1'b0;
						hit_q   <= 1'b0;
						if ((item.mode == MODE_PACKET) &&
							((item.hw_type != HW_ETHERNET) ||
							(item.proto_type != PROTO_IPV4))) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (ram_re) begin
						addr_s1 <= cnt_q[IDX_W-1:0];
						cnt_q   <= cnt_q + 1'b1;
					end
					if (match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= addr_s1;
						hit_mac_q <= ram_rdata.mac;
						pend_s1   <= 1'b0;
						state_q   <= S_FINISH;
					end else if (pend_s1 && (addr_s1 == LAST_IDX)) begin
						pend_s1 <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						pend_s1 <= ram_re;
					end
				end
				S_FINISH: begin
					result <= fin_res;
					if (insert) begin
						valid_q[ptr_q] <= 1'b1;
						ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back to back result strobes");

	a_insert_advances: assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> (ptr_q != $past(ptr_q)) && valid_q[$past(ptr_q)])
		else $error("insert did not mark entry valid and advance pointer");

	a_write_needs_packet: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (req_q.mode == MODE_PACKET) && (state_q == S_FINISH))
		else $error("cache written outside a packet transaction");

	a_lookup_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_HIT || result.status == ST_MISS) |->
		(result.reply_mac == '0) && (result.reply_ip == '0))
		else $error("lookup result carries reply addressing");

endmodule
